/* hdl/wgm_pkg.sv */
// ----------------------------------------------------------------------------
// wgm_pkg - shared types and constants of the wildcard glob matcher
// Pattern limits, wildcard codes and the structs passed along the cell chain.
// ----------------------------------------------------------------------------
package wgm_pkg;

    // Pattern limits
    localparam int MAX_PATTERN = 16;
    localparam int HELD_CHARS  = 16;
    localparam int NUM_CELLS   = (MAX_PATTERN < HELD_CHARS) ? MAX_PATTERN : HELD_CHARS;
    localparam int POS_W       = $clog2(NUM_CELLS + 1);
    localparam int LEN_W       = 5;
    localparam int CHAR_W      = 8;
    localparam int WORD_W      = 64;

    // Wildcard codes
    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 2'd2;

    // Per-beat control broadcast to every cell
    typedef struct packed {
        logic              use_start;  // current set is the start set
        logic              load;       // accepted beat that is not the last
        logic              step;       // current beat carries a byte
        logic [CHAR_W-1:0] ch;         // text byte
    } wgm_ctrl_t;

    // Signals handed from one cell to the next
    typedef struct packed {
        logic adv;     // previous position consumed the byte
        logic close;   // previous position is a live star in the new set
        logic start;   // previous position is a live star in the start set
    } wgm_link_t;

endpackage

/* hdl/wgm_config.sv */
// ----------------------------------------------------------------------------
// wgm_config - pattern registers of the wildcard glob matcher
// Holds the pattern bytes and length, and hands each cell its byte and enable.
// ----------------------------------------------------------------------------
module wgm_config
    import wgm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output logic                 cfg_write,
    output logic [CHAR_W-1:0]    cell_char [NUM_CELLS+1],
    output logic [NUM_CELLS:0]   cell_en,
    output logic [POS_W-1:0]     eff_len
);

    logic [WORD_W-1:0]   chars_low_reg;
    logic [WORD_W-1:0]   chars_high_reg;
    logic [LEN_W-1:0]    length_reg;
    logic [2*WORD_W-1:0] chars_all;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
            length_reg     <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                REG_CHARS_HIGH: chars_high_reg <= cfg_data;
                REG_LENGTH:     length_reg     <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp length to the number of cells
    assign eff_len = (length_reg > LEN_W'(NUM_CELLS)) ? POS_W'(NUM_CELLS)
                                                      : POS_W'(length_reg);
    assign chars_all = {chars_high_reg, chars_low_reg};

    // Hand each cell its byte and enable; the end cell has no byte
    always_comb begin
        for (int i = 0; i < NUM_CELLS; i++) begin
            cell_char[i] = chars_all[i*CHAR_W +: CHAR_W];
            cell_en[i]   = POS_W'(i) < eff_len;
        end
        cell_char[NUM_CELLS] = '0;
        cell_en[NUM_CELLS]   = 1'b0;
    end

endmodule

/* hdl/wgm_cell.sv */
// ----------------------------------------------------------------------------
// wgm_cell - one pattern position of the wildcard glob matcher
// Holds the alive bit of its position, consumes the text byte and passes
// advance and star-closure signals to the next position.
// ----------------------------------------------------------------------------
module wgm_cell
    import wgm_pkg::*;
(
    input  logic              aclk,
    input  wgm_ctrl_t         ctrl,
    input  logic [CHAR_W-1:0] pat_char,
    input  logic              en,
    input  wgm_link_t         link_in,
    output wgm_link_t         link_out,
    output logic              alive_next
);

    logic alive_reg;
    logic is_star;
    logic hit;
    logic cur;
    logic raw_new;
    logic stepped;

    assign is_star = (pat_char == STAR_CHAR);
    assign hit     = (pat_char == ANY_CHAR) || (pat_char == ctrl.ch);

    // Current membership: start set right after a restart
    assign cur = ctrl.use_start ? link_in.start : alive_reg;

    // Advance over the byte, then close over the star before us
    assign raw_new = (en && cur && is_star) || link_in.adv;
    assign stepped = raw_new || link_in.close;

    assign alive_next = ctrl.step ? stepped : cur;

    // Hand results to the next position
    assign link_out.adv   = en && cur && !is_star && hit;
    assign link_out.close = en && is_star && stepped;
    assign link_out.start = en && is_star && link_in.start;

    // Hold the alive bit between beats
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            alive_reg <= alive_next;
        end
    end

endmodule

/* hdl/wildcard_glob_matcher.sv */
// ----------------------------------------------------------------------------
// wildcard_glob_matcher - whole-text glob match with '*' and '?'
// Streams text bytes through a row of position cells and reports the match.
// ----------------------------------------------------------------------------
// Takes one text byte per clock, with no gaps between texts, while the output
// register is free or drained; a text's result is registered in the cycle
// after its last beat is accepted. The per-beat work is one pass through the
// row of position cells, where each cell compares the byte with its pattern
// character and the star closure ripples from cell to cell. A register write,
// and the last beat of each text, restarts matching from the start set of the
// current pattern. An empty text is one beat with s_tuser and s_tlast high.
module wildcard_glob_matcher
    import wgm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // text input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] character
    input  logic                 s_tlast,   // is_last
    input  logic                 s_tuser,   // no_char
    // match result
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [0] matched, [7:1] zero
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic                 cfg_write;
    logic [CHAR_W-1:0]    cell_char [NUM_CELLS+1];
    logic [NUM_CELLS:0]   cell_en;
    logic [POS_W-1:0]     eff_len;
    wgm_link_t            links [NUM_CELLS+2];
    logic [NUM_CELLS:0]   alive_next;
    wgm_ctrl_t            ctrl;
    logic                 in_acc;
    logic                 restart_reg;
    logic                 m_valid_reg;
    logic                 m_matched_reg;

    wgm_config u_config (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_write (cfg_write),
        .cell_char (cell_char),
        .cell_en   (cell_en),
        .eff_len   (eff_len)
    );

    // Accept while the output register is free or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    assign ctrl.use_start = restart_reg;
    assign ctrl.load      = in_acc && !s_tlast;
    assign ctrl.step      = !s_tuser;
    assign ctrl.ch        = s_tdata;

    // Position zero is the seed of the start set
    assign links[0].adv   = 1'b0;
    assign links[0].close = 1'b0;
    assign links[0].start = 1'b1;

    // Row of position cells, the last one standing for the pattern end
    for (genvar g = 0; g <= NUM_CELLS; g++) begin : g_cell
        wgm_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .pat_char   (cell_char[g]),
            .en         (cell_en[g]),
            .link_in    (links[g]),
            .link_out   (links[g+1]),
            .alive_next (alive_next[g])
        );
    end

    // Restart after reset, a register write or the end of a text
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            restart_reg <= 1'b1;
        end else if (cfg_write || (in_acc && s_tlast)) begin
            restart_reg <= 1'b1;
        end else if (in_acc) begin
            restart_reg <= 1'b0;
        end
    end

    // Output register: capture the pattern-end bit on the last beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_acc && s_tlast) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && s_tlast) begin
            m_matched_reg <= alive_next[eff_len];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_matched_reg};

    // A last beat always leaves a result pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tlast) |=> m_valid_reg)
        else $error("last beat did not produce a result");

    // Other beats never create a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && !(in_acc && s_tlast)) |=> !m_valid_reg)
        else $error("result raised without a last beat");

    // Matching restarts after a text ends or the pattern changes
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((in_acc && s_tlast) || cfg_write) |=> restart_reg)
        else $error("start set not restored");

    // A pending result that is not taken holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_matched_reg)))
        else $error("pending result lost or changed");

endmodule

/* verif/wildcard_glob_matcher_test.sv */
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_test - self-checking bench for the glob matcher
// Streams texts against a range of star and question-mark patterns, tracks
// the set of live pattern positions for every accepted beat, and compares
// each match verdict with the predicted one under random stalls on both sides.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_test;
    import wgm_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int STALL_PCT     = 34;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BEATS   = 88;
    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 8;

    // Index that decodes to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Tracks live pattern positions and the verdicts still owed by the block
    class glob_match_tracker;
        logic [WORD_W-1:0]  chars_low;
        logic [WORD_W-1:0]  chars_high;
        logic [LEN_W-1:0]   length_reg;
        logic [NUM_CELLS:0] live_pos;
        bit                 pending_matches[$];
        int                 errors;
        int                 hits;
        int                 misses;

        function new();
            chars_low  = '0;
            chars_high = '0;
            length_reg = '0;
            errors     = 0;
            hits       = 0;
            misses     = 0;
            live_pos   = close_over_stars((NUM_CELLS+1)'(1));
        endfunction

        // Clamp the length register to the cells that exist
        function int eff_len();
            return (length_reg > NUM_CELLS) ? NUM_CELLS : int'(length_reg);
        endfunction

        function logic [CHAR_W-1:0] pat_char(int i);
            logic [WORD_W-1:0] word;
            word = (i < 8) ? chars_low : chars_high;
            return word[(i % 8) * 8 +: 8];
        endfunction

        // Propagate live stars to the next position, chaining through runs
        function logic [NUM_CELLS:0] close_over_stars(logic [NUM_CELLS:0] pos);
            int n;
            n = eff_len();
            for (int i = 0; i < n; i++)
                if (pos[i] && pat_char(i) == STAR_CHAR)
                    pos[i + 1] = 1'b1;
            return pos;
        endfunction

        function logic [NUM_CELLS:0] live_after_char(logic [NUM_CELLS:0] pos,
                                                     logic [CHAR_W-1:0] ch);
            logic [NUM_CELLS:0] nxt;
            logic [CHAR_W-1:0]  p;
            int                 n;
            nxt = '0;
            n   = eff_len();
            for (int i = 0; i < n; i++) begin
                p = pat_char(i);
                if (pos[i]) begin
                    if (p == STAR_CHAR)
                        nxt[i] = 1'b1;
                    else if (p == ANY_CHAR || p == ch)
                        nxt[i + 1] = 1'b1;
                end
            end
            return close_over_stars(nxt);
        endfunction

        // A write to a real register restarts from the new start set
        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
            case (idx)
                REG_CHARS_LOW:  chars_low  = value;
                REG_CHARS_HIGH: chars_high = value;
                REG_LENGTH:     length_reg = value[LEN_W-1:0];
                default:        return;
            endcase
            live_pos = close_over_stars((NUM_CELLS+1)'(1));
        endfunction

        function void take_text_beat(logic [CHAR_W-1:0] ch, bit last, bit no_char);
            logic [NUM_CELLS:0] pos;
            pos = live_pos;
            if (!no_char)
                pos = live_after_char(pos, ch);
            if (!last) begin
                live_pos = pos;
            end else begin
                pending_matches.push_back(pos[eff_len()]);
                live_pos = close_over_stars((NUM_CELLS+1)'(1));
            end
        endfunction

        function void check_match_beat(logic [7:0] data);
            bit want;
            if (pending_matches.size() == 0) begin
                errors++;
                $display("%0t: result beat 0x%02h with no text pending", $time, data);
                return;
            end
            want = pending_matches.pop_front();
            if (want)
                hits++;
            else
                misses++;
            if (data !== {7'b0, want}) begin
                errors++;
                $display("%0t: matched mismatch, expected tdata 0x%02h, got 0x%02h",
                         $time, {7'b0, want}, data);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CHARS_LOW;
    logic [WORD_W-1:0]    cfg_data = '0;

    glob_match_tracker matcher = new();

    bit         gaps_on = 1'b1;
    int         text_beats = 0;
    int         texts_sent = 0;
    int         pattern_sets = 0;
    int         cfg_writes = 0;
    logic [7:0] text_q[$];
    logic       res_beat = 1'b0;
    logic [7:0] res_data = '0;

    wildcard_glob_matcher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Stall the result side at random
    always @(negedge aclk) begin
        m_tready <= gaps_on ? ($urandom_range(99) >= STALL_PCT) : 1'b1;
    end

    // Capture result beats at the rising edge, check them at the falling edge
    always @(posedge aclk) begin
        res_beat <= aresetn && m_tvalid && m_tready;
        res_data <= m_tdata;
    end

    always @(negedge aclk) begin
        if (res_beat)
            matcher.check_match_beat(res_data);
    end

    // Abort when no channel moves a beat for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [7:0] pick_text_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return (roll < 3) ? STAR_CHAR : ANY_CHAR;
        if (roll < 75)
            return 8'h61 + 8'($urandom_range(2));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_pattern_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return STAR_CHAR;
        if (roll < 50)
            return ANY_CHAR;
        if (roll < 85)
            return 8'h61 + 8'($urandom_range(2));
        return 8'($urandom_range(255));
    endfunction

    // Mostly texts shaped by the pattern, some mutated, the rest noise
    function automatic void build_text();
        logic [CHAR_W-1:0] p;
        text_q.delete();
        if ($urandom_range(99) < 65) begin
            for (int i = 0; i < matcher.eff_len(); i++) begin
                p = matcher.pat_char(i);
                if (p == STAR_CHAR)
                    repeat ($urandom_range(3)) text_q.push_back(pick_text_char());
                else if (p == ANY_CHAR)
                    text_q.push_back(pick_text_char());
                else
                    text_q.push_back(p);
            end
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(2))
                    0: if (text_q.size() != 0)
                        text_q[$urandom_range(text_q.size() - 1)] = pick_text_char();
                    1: text_q.push_back(pick_text_char());
                    default: if (text_q.size() != 0)
                        void'(text_q.pop_back());
                endcase
            end
        end else begin
            repeat ($urandom_range(10)) text_q.push_back(pick_text_char());
        end
    endfunction

    // Present one text beat and hold it until accepted; returns at a falling edge
    task automatic send_beat(input logic [7:0] ch, input bit last, input bit no_char);
        while (gaps_on && $urandom_range(99) < STALL_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        s_tuser  <= no_char;
        do @(posedge aclk); while (!s_tready);
        matcher.take_text_beat(ch, last, no_char);
        if (last || !no_char)
            text_beats++;
        if (last)
            texts_sent++;
        @(negedge aclk);
    endtask

    // Send text_q, with stray byteless beats and sometimes a byteless tail
    task automatic send_text();
        bit tail_empty;
        tail_empty = ($urandom_range(9) == 0);
        if (text_q.size() == 0) begin
            send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
            return;
        end
        foreach (text_q[i]) begin
            if ($urandom_range(19) == 0)
                send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
            send_beat(text_q[i], (i == text_q.size() - 1) && !tail_empty, 1'b0);
        end
        if (tail_empty)
            send_beat(8'($urandom_range(255)), 1'b1, 1'b1);
    endtask

    // Drop valid and hold off until every owed verdict has arrived
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (matcher.pending_matches.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        matcher.apply_write(idx, value);
        cfg_writes++;
        @(negedge aclk);
    endtask

    task automatic set_pattern(input logic [WORD_W-1:0] low, input logic [WORD_W-1:0] high,
                               input logic [WORD_W-1:0] len_word, input bit poke_unused);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(REG_CHARS_LOW, low);
        write_reg(REG_CHARS_HIGH, high);
        write_reg(REG_LENGTH, len_word);
        if (poke_unused)
            write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        pattern_sets++;
    endtask

    initial begin
        logic [2*WORD_W-1:0] chars;
        logic [WORD_W-1:0]   len_word;
        int                  goal;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty pattern after reset: only the empty text matches
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b0);

        // lone star: everything matches, a byteless beat mid-text is ignored
        set_pattern(64'h2A, '0, 64'd1, 1'b0);
        send_beat(8'h5A, 1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h11, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b0);

        // "a?" with junk above the length; the last text dies on its first byte
        set_pattern(64'h3F61, '1, 64'd2, 1'b1);
        send_beat(8'h61, 1'b0, 1'b0);
        send_beat(8'h5A, 1'b1, 1'b0);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h78, 1'b0, 1'b0);
        send_beat(8'h61, 1'b0, 1'b0);
        send_beat(8'h5A, 1'b1, 1'b0);

        // overlong length clamps to sixteen: eight stars, seven '?', then 'b'
        set_pattern(64'h2A2A_2A2A_2A2A_2A2A, 64'h623F_3F3F_3F3F_3F3F, 64'd31, 1'b0);
        send_beat(8'h2A, 1'b0, 1'b0);
        send_beat(8'h3F, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h10, 1'b0, 1'b0);
        send_beat(8'h20, 1'b0, 1'b0);
        send_beat(8'h30, 1'b0, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1);

        // random patterns, extremes first, two phases without any stalls
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (int i = 0; i < 2 * HELD_CHARS / 2; i++)
                chars[8 * i +: 8] = pick_pattern_char();
            len_word = {$urandom, $urandom};
            if ($urandom_range(3) != 0)
                len_word[LEN_W-1:0] = LEN_W'($urandom_range(8, 1));
            case (ph)
                0: len_word[LEN_W-1:0] = 5'd16;
                1: len_word = '1;
                2: begin
                    chars    = '0;
                    len_word = '0;
                end
                3: begin
                    chars = '1;
                    len_word[LEN_W-1:0] = 5'd16;
                end
                default: ;
            endcase
            set_pattern(chars[WORD_W-1:0], chars[2*WORD_W-1:WORD_W], len_word, ph == 6);
            gaps_on <= !(ph == 4 || ph == 5);
            @(negedge aclk);

            goal = text_beats + PHASE_BEATS;
            while (text_beats < goal) begin
                build_text();
                send_text();
                // now and then let the result side run dry mid-phase
                if ($urandom_range(39) == 0)
                    wait_all_results();
            end
        end

        wait_all_results();
        repeat (END_CYCLES) @(negedge aclk);

        $display("Covered %0d texts in %0d beats over %0d patterns, %0d register writes.",
                 texts_sent, text_beats, pattern_sets, cfg_writes);
        $display("Verdicts: %0d matched, %0d not matched, %0d errors.",
                 matcher.hits, matcher.misses, matcher.errors);
        if (matcher.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
